/* rtl/core/lpe_pkg.sv */
// ----------------------------------------------------------------------------
// lpe_pkg
// Shared constants and controller/datapath interface types for the Legendre
// polynomial evaluator.
// ----------------------------------------------------------------------------
package lpe_pkg;

  // Fixed port widths
  localparam int X_W   = 32;
  localparam int DEG_W = 8;
  localparam int OUT_W = 32;

  // Default parameter values
  localparam int DEF_MAX_DEGREE = 255;
  localparam int DEF_FRAC_BITS  = 30;

  // Multiplier operand chunk and divider digit widths
  localparam int CHUNK_W = 32;
  localparam int DIG_W   = 8;

  // Result source select
  typedef enum logic [1:0] {
    SEL_LOWER = 2'd0,
    SEL_TOP   = 2'd1,
    SEL_ONE   = 2'd2
  } res_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     req_load;
    logic     cache_restart;
    logic     mul_start;
    logic     mul_step;
    logic     term_load;
    logic     div_start;
    logic     div_step;
    logic     sub_calc;
    logic     cache_advance;
    logic     res_load;
    res_sel_t res_sel;
  } lpe_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit_lower;
    logic hit_top;
    logic resume;
    logic at_target;
    logic deg_zero;
    logic mul_last;
    logic div_last;
  } lpe_sts_t;

endpackage

/* rtl/core/lpe_ctrl.sv */
// ----------------------------------------------------------------------------
// lpe_ctrl
// Sequencer for the evaluator: cache lookup, recurrence step sequencing
// (multiply, divide, update) and the output register handshake.
// ----------------------------------------------------------------------------
module lpe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lpe_pkg::lpe_sts_t sts,
  output lpe_pkg::lpe_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CHECK,
    ST_MUL,
    ST_TERM,
    ST_DIVLD,
    ST_DIV,
    ST_SUB,
    ST_UPD,
    ST_RES
  } state_t;

  state_t            state;
  state_t            state_next;
  lpe_pkg::res_sel_t sel;
  lpe_pkg::res_sel_t sel_next;

  // One request at a time
  assign in_stall = (state != ST_IDLE);

  // Next state and commands
  always_comb begin
    cmd         = '0;
    cmd.res_sel = sel;
    state_next  = state;
    sel_next    = sel;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_next   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (sts.hit_lower) begin
          sel_next   = lpe_pkg::SEL_LOWER;
          state_next = ST_RES;
        end else if (sts.hit_top) begin
          sel_next   = lpe_pkg::SEL_TOP;
          state_next = ST_RES;
        end else if (sts.resume) begin
          state_next = ST_CHECK;
        end else begin
          cmd.cache_restart = 1'b1;
          if (sts.deg_zero) begin
            sel_next   = lpe_pkg::SEL_ONE;
            state_next = ST_RES;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sts.at_target) begin
          sel_next   = lpe_pkg::SEL_TOP;
          state_next = ST_RES;
        end else begin
          cmd.mul_start = 1'b1;
          state_next    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) state_next = ST_TERM;
      end
      ST_TERM: begin
        cmd.term_load = 1'b1;
        state_next    = ST_DIVLD;
      end
      ST_DIVLD: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub_calc = 1'b1;
        state_next   = ST_UPD;
      end
      ST_UPD: begin
        cmd.cache_advance = 1'b1;
        state_next        = ST_CHECK;
      end
      ST_RES: begin
        // output register free, or emptied this cycle
        if (!(out_valid && out_stall)) begin
          cmd.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sel       <= lpe_pkg::SEL_LOWER;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/lpe_datapath.sv */
// ----------------------------------------------------------------------------
// lpe_datapath
// Request registers, recurrence cache, chunked magnitude multiplier,
// digit-per-cycle divider by the degree and the result register.
// ----------------------------------------------------------------------------
module lpe_datapath #(
  parameter int MAX_DEGREE = lpe_pkg::DEF_MAX_DEGREE,
  parameter int FRAC_BITS  = lpe_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [lpe_pkg::X_W-1:0]    x_value,
  input  logic        [lpe_pkg::DEG_W-1:0]  degree,
  input  lpe_pkg::lpe_cmd_t                 cmd,
  output lpe_pkg::lpe_sts_t                 sts,
  output logic signed [lpe_pkg::OUT_W-1:0]  poly_value
);

  localparam int VW   = FRAC_BITS + 2;
  localparam int EW   = FRAC_BITS + 4;
  localparam int XW   = (VW > lpe_pkg::X_W) ? VW : lpe_pkg::X_W;
  localparam int DW   = $clog2(MAX_DEGREE + 1);
  localparam int LW   = (DW > lpe_pkg::DEG_W) ? DW : lpe_pkg::DEG_W;
  localparam int OW   = lpe_pkg::OUT_W;
  localparam int MW   = FRAC_BITS + 1;
  localparam int CW   = lpe_pkg::CHUNK_W;
  localparam int NCH  = (MW + CW - 1) / CW;
  localparam int AW   = NCH * CW;
  localparam int PW   = 2 * AW;
  localparam int SHW  = $clog2(PW);
  localparam int CNW  = $clog2(NCH + 1);
  localparam int RW   = FRAC_BITS + 2;
  localparam int DG   = lpe_pkg::DIG_W;
  localparam int NDIG = (RW + DG - 1) / DG;
  localparam int DVW  = NDIG * DG;
  localparam int DCW  = $clog2(NDIG + 1);

  localparam logic signed [VW-1:0] ONE_V = {2'b01, {FRAC_BITS{1'b0}}};
  localparam logic signed [EW-1:0] ONE_E = {4'b0001, {FRAC_BITS{1'b0}}};
  localparam logic signed [XW-1:0] ONE_X =
    {{(XW - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [LW-1:0] MAXD_L = LW'(MAX_DEGREE);

  // Request registers
  logic signed [VW-1:0] x_req;
  logic        [DW-1:0] l_req;

  // Recurrence cache
  logic signed [VW-1:0] pt;
  logic        [DW-1:0] top_deg;
  logic        [DW-1:0] low_deg;
  logic signed [VW-1:0] top_val;
  logic signed [VW-1:0] low_val;

  // Input saturation
  logic signed [XW-1:0] x_ext;
  logic signed [VW-1:0] x_sat;
  logic        [LW-1:0] l_ext;
  logic        [DW-1:0] l_sat;

  assign x_ext = XW'(x_value);
  assign l_ext = LW'(degree);

  always_comb begin
    priority if (x_ext > ONE_X) begin
      x_sat = ONE_V;
    end else if (x_ext < -ONE_X) begin
      x_sat = -ONE_V;
    end else begin
      x_sat = VW'(x_ext);
    end
  end

  assign l_sat = (l_ext > MAXD_L) ? DW'(MAXD_L) : DW'(l_ext);

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      x_req <= x_sat;
      l_req <= l_sat;
    end
  end

  // Cache lookup status
  logic          same_pt;
  logic [DW-1:0] i_deg;

  assign same_pt       = (x_req == pt);
  assign i_deg         = top_deg + DW'(1);
  assign sts.hit_lower = same_pt && (l_req == low_deg);
  assign sts.hit_top   = same_pt && (l_req == top_deg);
  assign sts.resume    = same_pt && (l_req > top_deg);
  assign sts.at_target = (top_deg == l_req);
  assign sts.deg_zero  = (l_req == '0);

  // Multiplier: |x| * |P_{i-1}| over NCH x NCH chunk products
  logic signed [VW-1:0]   x_abs;
  logic signed [VW-1:0]   top_abs;
  logic        [AW-1:0]   a_rot;
  logic        [AW-1:0]   b_rot;
  logic        [PW-1:0]   acc;
  logic        [SHW-1:0]  sh;
  logic        [SHW-1:0]  row_sh;
  logic        [CNW-1:0]  a_cnt;
  logic        [CNW-1:0]  b_cnt;
  logic                   mul_neg;
  logic        [2*CW-1:0] pp;
  logic                   row_end;

  assign x_abs   = x_req[VW-1] ? -x_req : x_req;
  assign top_abs = top_val[VW-1] ? -top_val : top_val;
  assign pp      = a_rot[CW-1:0] * b_rot[CW-1:0];
  assign row_end = (a_cnt == CNW'(1));
  assign sts.mul_last = row_end && (b_cnt == CNW'(1));

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      a_rot   <= AW'(x_abs[MW-1:0]);
      b_rot   <= AW'(top_abs[MW-1:0]);
      acc     <= '0;
      sh      <= '0;
      row_sh  <= '0;
      a_cnt   <= CNW'(NCH);
      b_cnt   <= CNW'(NCH);
      mul_neg <= x_req[VW-1] ^ top_val[VW-1];
    end else if (cmd.mul_step) begin
      acc   <= acc + (PW'(pp) << sh);
      a_rot <= (a_rot >> CW) | (a_rot << (AW - CW));
      if (row_end) begin
        a_cnt  <= CNW'(NCH);
        b_cnt  <= b_cnt - CNW'(1);
        b_rot  <= b_rot >> CW;
        row_sh <= row_sh + SHW'(CW);
        sh     <= row_sh + SHW'(CW);
      end else begin
        a_cnt <= a_cnt - CNW'(1);
        sh    <= sh + SHW'(CW);
      end
    end
  end

  // Truncated product t = x * P_{i-1}, toward zero
  logic signed [VW-1:0] t_s;
  logic signed [VW-1:0] t_q;

  assign t_s = {1'b0, acc[FRAC_BITS +: MW]};

  always_ff @(posedge clk) begin
    if (cmd.term_load) begin
      t_q <= mul_neg ? -t_s : t_s;
    end
  end

  // k = 2t - q, r = t - q; result is k - r/i with truncation fix-up
  logic signed [EW-1:0] k_d;
  logic signed [EW-1:0] r_d;
  logic signed [EW-1:0] r_abs;
  logic signed [EW-1:0] k_q;
  logic                 r_neg;

  assign k_d   = (EW'(t_q) <<< 1) - EW'(low_val);
  assign r_d   = EW'(t_q) - EW'(low_val);
  assign r_abs = r_d[EW-1] ? -r_d : r_d;

  // Divider: |r| / i, DG quotient bits per cycle; remainder stays below i
  logic [DVW-1:0] dq;
  logic [DW-1:0]  rem;
  logic [DCW-1:0] dcnt;
  logic [DVW-1:0] dq_w;
  logic [DW-1:0]  rem_w;
  logic [DW:0]    trial;

  always_comb begin
    dq_w  = dq;
    rem_w = rem;
    trial = '0;
    for (int s = 0; s < DG; s++) begin
      trial = {rem_w, dq_w[DVW-1]};
      dq_w  = dq_w << 1;
      if (trial >= {1'b0, i_deg}) begin
        rem_w   = DW'(trial - {1'b0, i_deg});
        dq_w[0] = 1'b1;
      end else begin
        rem_w = trial[DW-1:0];
      end
    end
  end

  assign sts.div_last = (dcnt == DCW'(1));

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      k_q   <= k_d;
      r_neg <= r_d[EW-1];
      dq    <= DVW'(r_abs[RW-1:0]);
      rem   <= '0;
      dcnt  <= DCW'(NDIG);
    end else if (cmd.div_step) begin
      dq   <= dq_w;
      rem  <= rem_w;
      dcnt <= dcnt - DCW'(1);
    end
  end

  // w = k - trunc(r / i)
  logic signed [EW-1:0] quot_e;
  logic signed [EW-1:0] w_q;
  logic                 rem_nz;

  assign quot_e = EW'({1'b0, dq[RW-1:0]});

  always_ff @(posedge clk) begin
    if (cmd.sub_calc) begin
      w_q    <= r_neg ? (k_q + quot_e) : (k_q - quot_e);
      rem_nz <= (rem != '0);
    end
  end

  // Fold the remainder term toward zero, then saturate to [-1, 1]
  logic signed [EW-1:0] v_adj;
  logic signed [VW-1:0] v_sat;

  always_comb begin
    v_adj = w_q;
    if (rem_nz && !r_neg && (w_q > 0)) begin
      v_adj = w_q - EW'(1);
    end else if (rem_nz && r_neg && (w_q < 0)) begin
      v_adj = w_q + EW'(1);
    end
  end

  always_comb begin
    priority if (v_adj > ONE_E) begin
      v_sat = ONE_V;
    end else if (v_adj < -ONE_E) begin
      v_sat = -ONE_V;
    end else begin
      v_sat = VW'(v_adj);
    end
  end

  // Cache update
  always_ff @(posedge clk) begin
    if (rst) begin
      pt      <= ONE_V;
      top_deg <= '0;
      low_deg <= '0;
      top_val <= ONE_V;
      low_val <= ONE_V;
    end else if (cmd.cache_restart) begin
      pt      <= x_req;
      top_deg <= DW'(1);
      low_deg <= '0;
      top_val <= x_req;
      low_val <= ONE_V;
    end else if (cmd.cache_advance) begin
      low_val <= top_val;
      top_val <= v_sat;
      low_deg <= top_deg;
      top_deg <= i_deg;
    end
  end

  // Result register
  logic signed [VW-1:0] res;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        lpe_pkg::SEL_LOWER: res <= low_val;
        lpe_pkg::SEL_TOP:   res <= top_val;
        lpe_pkg::SEL_ONE:   res <= ONE_V;
        default:            res <= ONE_V;
      endcase
    end
  end

  assign poly_value = OW'(res);

endmodule

/* rtl/core/legendre_polynomial_eval_unit.sv */
// Sequence: a cache hit or degree 0 at a new point goes from the decide state to the result state;
// otherwise the unit climbs one recurrence step per degree. Each step runs the chunk products,
// one 32x32 chunk product per cycle, then the term load, the divider load and the divider by i,
//   at 8 quotient bits per cycle, then the subtract and the cache update.
// Throughput: one request in flight; the next is taken the cycle after the result is loaded.
// Reset: cache holds P_0 = 1.0 at x = 1.0, no result pending, input side ready.
// ----------------------------------------------------------------------------
// legendre_polynomial_eval_unit
// Evaluates P_l(x) in signed fixed point by Bonnet's recurrence, resuming
// from the cached last two degrees when the point repeats and l is not below them.
// ----------------------------------------------------------------------------
module legendre_polynomial_eval_unit #(
  parameter int MAX_DEGREE = lpe_pkg::DEF_MAX_DEGREE,
  parameter int FRAC_BITS  = lpe_pkg::DEF_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [lpe_pkg::X_W-1:0]    x_value,
  input  logic        [lpe_pkg::DEG_W-1:0]  degree,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [lpe_pkg::OUT_W-1:0]  poly_value
);

  lpe_pkg::lpe_cmd_t cmd;
  lpe_pkg::lpe_sts_t sts;

  // Sequencer
  lpe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and cache
  lpe_datapath #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .x_value    (x_value),
    .degree     (degree),
    .cmd        (cmd),
    .sts        (sts),
    .poly_value (poly_value)
  );

endmodule

/* rtl/core/lpe_checker.sv */
// ----------------------------------------------------------------------------
// lpe_checker
// Port-level checks for the Legendre evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module lpe_checker #(
  parameter int FRAC_BITS = lpe_pkg::DEF_FRAC_BITS
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [lpe_pkg::OUT_W-1:0] poly_value
);

  localparam logic signed [63:0] ONE_C = 64'sd1 <<< FRAC_BITS;

  logic signed [63:0] pv;
  assign pv = 64'(poly_value);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(poly_value)))
    else $error("result changed or dropped while stalled");

  // Reset leaves nothing pending and the input open
  a_reset: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("state after reset wrong");

  // One request in flight: the input closes right after a request is taken
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while busy");

  // Results stay within [-1, 1] where +1.0 fits the port
  a_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (FRAC_BITS <= 30)) |-> ((pv <= ONE_C) && (pv >= -ONE_C)))
    else $error("result out of range");

endmodule

bind legendre_polynomial_eval_unit lpe_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_lpe_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .poly_value (poly_value)
);
